>>> rtl/core/cft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cft_pkg
// Shared types and constants of the CSV field tokenizer.
// ----------------------------------------------------------------------------
package cft_pkg;

  localparam int MAX_COLUMNS = 256;
  localparam int PENDING_MAX = 16;

  localparam int COL_W  = 8;
  localparam int TOT_W  = 9;
  localparam int PCNT_W = $clog2(PENDING_MAX + 1);
  localparam int PIDX_W = (PENDING_MAX > 1) ? $clog2(PENDING_MAX) : 1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  localparam logic [1:0] K_BYTE  = 2'd0;
  localparam logic [1:0] K_FIELD = 2'd1;
  localparam logic [1:0] K_ROW   = 2'd2;
  localparam logic [1:0] K_ERROR = 2'd3;

  localparam logic [2:0] E_UNCLOSED  = 3'd0;
  localparam logic [2:0] E_AFTER_Q   = 3'd1;
  localparam logic [2:0] E_TOO_MANY  = 3'd2;
  localparam logic [2:0] E_TOO_FEW   = 3'd3;
  localparam logic [2:0] E_EMPTY     = 3'd4;
  localparam logic [2:0] E_WS_OVF    = 3'd5;
  localparam logic [2:0] E_COL_OVF   = 3'd6;

  typedef struct packed {
    logic [1:0]       out_kind;
    logic [7:0]       data_byte;
    logic [COL_W-1:0] column;
    logic             in_header;
    logic [2:0]       error_code;
    logic             last;
  } cft_res_t;

  typedef struct packed {
    logic [PCNT_W-1:0] flush_n;
    logic [1:0]        out_kind;
    logic [7:0]        data_byte;
    logic [COL_W-1:0]  column;
    logic              in_header;
    logic [2:0]        error_code;
  } cft_desc_t;

  typedef struct packed {
    logic              en;
    logic [PIDX_W-1:0] idx;
    logic [7:0]        data;
  } cft_pwr_t;

endpackage

>>> rtl/core/cft_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cft_in_if / cft_out_if
// Valid/ready channels of the CSV field tokenizer.
// ----------------------------------------------------------------------------
interface cft_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_in;

  modport source (output valid, kind, byte_in, input ready);
  modport sink (input valid, kind, byte_in, output ready);
endinterface

interface cft_out_if import cft_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       out_kind;
  logic [7:0]       data_byte;
  logic [COL_W-1:0] column;
  logic             in_header;
  logic [2:0]       error_code;
  logic             last;

  modport source (output valid, out_kind, data_byte, column, in_header, error_code, last,
                  input ready);
  modport sink (input valid, out_kind, data_byte, column, in_header, error_code, last,
                output ready);
endinterface

>>> rtl/core/csv_field_tokenizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_field_tokenizer_top
// CSV field tokenizer: trims whitespace, handles quoted fields, checks
// column counts against the header row, emits bytes, field and row ends and errors.
//
//   port   dir   payload                                          handshake
//   din    in    kind, byte_in                                     valid/ready
//   dout   out   out_kind, data_byte, column, in_header,           valid/ready
//                error_code, last
//
// One input item per cycle when it yields at most one result and the output
// queue has room. A byte that ends held whitespace yields pending_count + 1
// results, one per cycle while the queue has room; din stalls until the last
// of them enters the output queue. din.ready comes from registers only; a
// two-entry output queue decouples it from dout.ready.
// rst is synchronous; errors and end of file hold until reset.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_top import cft_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  cft_in_if.sink    din,
  cft_out_if.source dout
);

  logic      desc_valid;
  logic      room;
  cft_desc_t desc;
  cft_pwr_t  pwr;

  cft_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .din        (din),
    .room       (room),
    .desc_valid (desc_valid),
    .desc       (desc),
    .pwr        (pwr)
  );

  cft_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (desc_valid),
    .desc       (desc),
    .pwr        (pwr),
    .room       (room),
    .dout       (dout)
  );

endmodule

>>> rtl/core/cft_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cft_parse
// Parse state machine: one input item per cycle while the emitter has room, produces a result
// descriptor and pending whitespace writes.
// ----------------------------------------------------------------------------
module cft_parse import cft_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  cft_in_if.sink    din,
  input  logic      room,
  output logic      desc_valid,
  output cft_desc_t desc,
  output cft_pwr_t  pwr
);

  localparam logic [2:0] M_START  = 3'd0;
  localparam logic [2:0] M_UNQ    = 3'd1;
  localparam logic [2:0] M_QUOTED = 3'd2;
  localparam logic [2:0] M_QSEEN  = 3'd3;
  localparam logic [2:0] M_AFTER  = 3'd4;
  localparam logic [2:0] M_ENDED  = 3'd5;
  localparam logic [2:0] M_ERROR  = 3'd6;

  logic [2:0]        mode, mode_next;
  logic [PCNT_W-1:0] pend, pend_next;
  logic [COL_W-1:0]  col, col_next;
  logic [TOT_W-1:0]  total, total_next;
  logic              hdr, hdr_next;

  logic              accept, ws, c_comma, c_nl, c_quote, pend_full;
  logic [TOT_W-1:0]  col_inc;
  logic              emit, do_fin, fin_row, do_err, eof_end;
  logic [1:0]        r_kind;
  logic [7:0]        r_data;
  logic [2:0]        r_err;
  logic [PCNT_W-1:0] r_flush;

  assign din.ready = room;
  assign accept    = din.valid && room;
  assign ws        = (din.byte_in == CH_SPACE) || (din.byte_in == CH_TAB);
  assign c_comma   = din.byte_in == CH_COMMA;
  assign c_nl      = din.byte_in == CH_NL;
  assign c_quote   = din.byte_in == CH_QUOTE;
  assign col_inc   = TOT_W'(col) + TOT_W'(1);
  assign pend_full = pend >= PCNT_W'(PENDING_MAX);

  always_comb begin
    mode_next  = mode;
    pend_next  = pend;
    col_next   = col;
    total_next = total;
    hdr_next   = hdr;
    emit       = 1'b0;
    do_fin     = 1'b0;
    fin_row    = 1'b0;
    do_err     = 1'b0;
    eof_end    = 1'b0;
    r_kind     = K_BYTE;
    r_data     = 8'd0;
    r_err      = E_UNCLOSED;
    r_flush    = '0;

    if (accept && (mode <= M_AFTER)) begin
      if (din.kind) begin
        unique case (mode)
          M_START: begin
            if (!hdr && (col == '0)) begin
              do_err = 1'b1;
              r_err  = E_EMPTY;
            end else if (hdr && (col == '0)) begin
              eof_end = 1'b1;
            end else begin
              do_fin  = 1'b1;
              fin_row = 1'b1;
              eof_end = 1'b1;
            end
          end
          M_UNQ, M_QSEEN, M_AFTER: begin
            do_fin  = 1'b1;
            fin_row = 1'b1;
            eof_end = 1'b1;
          end
          M_QUOTED: begin
            do_err = 1'b1;
            r_err  = E_UNCLOSED;
          end
          default: ;
        endcase
      end else begin
        unique case (mode)
          M_START: begin
            if (ws) begin
            end else if (c_comma || c_nl) begin
              do_fin  = 1'b1;
              fin_row = c_nl;
            end else if (c_quote) begin
              mode_next = M_QUOTED;
            end else begin
              mode_next = M_UNQ;
              pend_next = '0;
              emit      = 1'b1;
              r_data    = din.byte_in;
            end
          end
          M_UNQ: begin
            if (ws) begin
              if (pend_full) begin
                do_err = 1'b1;
                r_err  = E_WS_OVF;
              end else begin
                pend_next = pend + PCNT_W'(1);
              end
            end else if (c_comma || c_nl) begin
              do_fin  = 1'b1;
              fin_row = c_nl;
            end else begin
              emit      = 1'b1;
              r_data    = din.byte_in;
              r_flush   = pend;
              pend_next = '0;
            end
          end
          M_QUOTED: begin
            if (c_quote) begin
              mode_next = M_QSEEN;
            end else begin
              emit   = 1'b1;
              r_data = din.byte_in;
            end
          end
          M_QSEEN, M_AFTER: begin
            if (c_quote && (mode == M_QSEEN)) begin
              mode_next = M_QUOTED;
              emit      = 1'b1;
              r_data    = din.byte_in;
            end else if (ws) begin
              mode_next = M_AFTER;
            end else if (c_comma || c_nl) begin
              do_fin  = 1'b1;
              fin_row = c_nl;
            end else begin
              do_err = 1'b1;
              r_err  = E_AFTER_Q;
            end
          end
          default: ;
        endcase
      end

      if (do_fin) begin
        pend_next = '0;
        mode_next = M_START;
        if (!hdr) begin
          if (fin_row) begin
            emit       = 1'b1;
            r_kind     = K_ROW;
            total_next = col_inc;
            hdr_next   = 1'b1;
            col_next   = '0;
          end else if (col_inc >= TOT_W'(MAX_COLUMNS)) begin
            do_err = 1'b1;
            r_err  = E_COL_OVF;
          end else begin
            emit     = 1'b1;
            r_kind   = K_FIELD;
            col_next = col_inc[COL_W-1:0];
          end
        end else if (fin_row) begin
          if (col_inc < total) begin
            do_err = 1'b1;
            r_err  = E_TOO_FEW;
          end else begin
            emit     = 1'b1;
            r_kind   = K_ROW;
            col_next = '0;
          end
        end else if (col_inc >= total) begin
          do_err = 1'b1;
          r_err  = E_TOO_MANY;
        end else begin
          emit     = 1'b1;
          r_kind   = K_FIELD;
          col_next = col_inc[COL_W-1:0];
        end
      end

      if (do_err) begin
        emit      = 1'b1;
        r_kind    = K_ERROR;
        r_data    = 8'd0;
        mode_next = M_ERROR;
        pend_next = '0;
      end else if (eof_end) begin
        mode_next = M_ENDED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= M_START;
      pend  <= '0;
      col   <= '0;
      total <= '0;
      hdr   <= 1'b0;
    end else begin
      mode  <= mode_next;
      pend  <= pend_next;
      col   <= col_next;
      total <= total_next;
      hdr   <= hdr_next;
    end
  end

  assign desc_valid      = emit;
  assign desc.flush_n    = r_flush;
  assign desc.out_kind   = r_kind;
  assign desc.data_byte  = r_data;
  assign desc.column     = col;
  assign desc.in_header  = !hdr;
  assign desc.error_code = (r_kind == K_ERROR) ? r_err : 3'd0;

  assign pwr.en   = accept && !din.kind && (mode == M_UNQ) && ws && !pend_full;
  assign pwr.idx  = pend[PIDX_W-1:0];
  assign pwr.data = din.byte_in;

  a_pend_range: assert property (@(posedge clk) disable iff (rst)
    pend <= PCNT_W'(PENDING_MAX))
    else $error("pending count beyond limit");

  a_hdr_total: assert property (@(posedge clk) disable iff (rst)
    hdr |-> (total != '0))
    else $error("header closed with zero columns");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (mode == M_ERROR) |=> (mode == M_ERROR) && !desc_valid)
    else $error("error state left or produced a result");

endmodule

>>> rtl/core/cft_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cft_emit
// Result expansion: holds one descriptor, plays out pending whitespace
// followed by the result, into a two-entry output queue.
// ----------------------------------------------------------------------------
module cft_emit import cft_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      desc_valid,
  input  cft_desc_t desc,
  input  cft_pwr_t  pwr,
  output logic      room,
  cft_out_if.source dout
);

  logic [7:0]        pend_mem [PENDING_MAX];
  cft_desc_t         d;
  logic              d_valid;
  logic [PCNT_W-1:0] idx;
  cft_res_t          q_mem [2];
  logic              wr_ptr, rd_ptr;
  logic [1:0]        cnt;
  logic              is_tmpl, push, pop;
  cft_res_t          res;

  assign is_tmpl = idx == d.flush_n;
  assign push    = d_valid && (cnt != 2'd2);
  assign pop     = dout.valid && dout.ready;
  assign room    = !d_valid || (is_tmpl && push);

  always_comb begin
    res.out_kind   = d.out_kind;
    res.data_byte  = d.data_byte;
    res.column     = d.column;
    res.in_header  = d.in_header;
    res.error_code = d.error_code;
    res.last       = 1'b1;
    if (!is_tmpl) begin
      res.out_kind   = K_BYTE;
      res.data_byte  = pend_mem[idx[PIDX_W-1:0]];
      res.error_code = 3'd0;
      res.last       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pwr.en) begin
      pend_mem[pwr.idx] <= pwr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (desc_valid) begin
      d <= desc;
    end
    if (push) begin
      q_mem[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      idx     <= '0;
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      cnt     <= 2'd0;
    end else begin
      if (desc_valid) begin
        d_valid <= 1'b1;
        idx     <= '0;
      end else if (push && is_tmpl) begin
        d_valid <= 1'b0;
      end else if (push) begin
        idx <= idx + PCNT_W'(1);
      end
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  assign dout.valid      = cnt != 2'd0;
  assign dout.out_kind   = q_mem[rd_ptr].out_kind;
  assign dout.data_byte  = q_mem[rd_ptr].data_byte;
  assign dout.column     = q_mem[rd_ptr].column;
  assign dout.in_header  = q_mem[rd_ptr].in_header;
  assign dout.error_code = q_mem[rd_ptr].error_code;
  assign dout.last       = q_mem[rd_ptr].last;

  a_desc_room: assert property (@(posedge clk) disable iff (rst)
    desc_valid |-> room)
    else $error("descriptor loaded while one is still playing out");

  a_pwr_safe: assert property (@(posedge clk) disable iff (rst)
    pwr.en |-> room)
    else $error("pending store written during a flush");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    d_valid |-> (idx <= d.flush_n))
    else $error("flush index past descriptor count");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= 2'd2)
    else $error("output queue overrun");

endmodule

>>> tb/cft_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cft_checker
// Watches both channels of the CSV field tokenizer. Each accepted input item
// runs through a behavioral tokenizer that yields the tokens it should cause;
// each accepted output token is compared field by field with the oldest one
// still waiting. Hands the mismatch count and the number of tokens still
// waiting to the testbench top.
// ----------------------------------------------------------------------------
module cft_checker import cft_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic             in_kind,
  input  logic [7:0]       in_byte,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [1:0]       out_kind,
  input  logic [7:0]       out_data_byte,
  input  logic [COL_W-1:0] out_column,
  input  logic             out_in_header,
  input  logic [2:0]       out_error_code,
  input  logic             out_last,
  output int unsigned      fail_count,
  output int unsigned      outstanding
);

  typedef enum logic [2:0] {
    PM_START,
    PM_UNQ,
    PM_QUOTED,
    PM_QSEEN,
    PM_AFTER,
    PM_ENDED,
    PM_ERROR
  } parse_mode_t;

  parse_mode_t mode;
  logic [7:0]  ws_hold [PENDING_MAX];
  int unsigned ws_cnt;
  int unsigned col_idx;
  int unsigned col_total;
  bit          hdr_done;
  bit          err_hold;
  int unsigned err_total;
  cft_res_t    expected_tokens_q[$];

  assign fail_count = err_total;

  function void clear_tokenizer();
    mode      = PM_START;
    ws_cnt    = 0;
    col_idx   = 0;
    col_total = 0;
    hdr_done  = 1'b0;
    err_hold  = 1'b0;
    foreach (ws_hold[i]) ws_hold[i] = 8'h00;
  endfunction

  function void emit(logic [1:0] k, logic [7:0] d, logic [2:0] code);
    cft_res_t r;
    r.out_kind   = k;
    r.data_byte  = d;
    r.column     = COL_W'(col_idx);
    r.in_header  = !hdr_done;
    r.error_code = code;
    r.last       = 1'b0;
    expected_tokens_q.push_back(r);
  endfunction

  function void flag_error(logic [2:0] code);
    emit(K_ERROR, 8'h00, code);
    mode     = PM_ERROR;
    err_hold = 1'b1;
    ws_cnt   = 0;
  endfunction

  function void close_field(bit row_end);
    ws_cnt = 0;
    if (!hdr_done) begin
      if (row_end) begin
        emit(K_ROW, 8'h00, 3'd0);
        col_total = col_idx + 1;
        hdr_done  = 1'b1;
        col_idx   = 0;
      end else if (col_idx + 1 >= MAX_COLUMNS) begin
        flag_error(E_COL_OVF);
        return;
      end else begin
        emit(K_FIELD, 8'h00, 3'd0);
        col_idx++;
      end
    end else if (row_end) begin
      if (col_idx + 1 < col_total) begin
        flag_error(E_TOO_FEW);
        return;
      end
      emit(K_ROW, 8'h00, 3'd0);
      col_idx = 0;
    end else begin
      if (col_idx + 1 >= col_total) begin
        flag_error(E_TOO_MANY);
        return;
      end
      emit(K_FIELD, 8'h00, 3'd0);
      col_idx++;
    end
    mode = PM_START;
  endfunction

  function void take_eof();
    case (mode)
      PM_START: begin
        if (!hdr_done && col_idx == 0) begin
          flag_error(E_EMPTY);
          return;
        end
        if (!(hdr_done && col_idx == 0)) close_field(1'b1);
      end
      PM_UNQ, PM_QSEEN, PM_AFTER: close_field(1'b1);
      PM_QUOTED: begin
        flag_error(E_UNCLOSED);
        return;
      end
      default: return;
    endcase
    if (mode != PM_ERROR) mode = PM_ENDED;
  endfunction

  function void take_byte(logic [7:0] c);
    bit ws;
    ws = (c == CH_SPACE) || (c == CH_TAB);
    case (mode)
      PM_START: begin
        if (ws) begin
        end else if (c == CH_COMMA) begin
          close_field(1'b0);
        end else if (c == CH_NL) begin
          close_field(1'b1);
        end else if (c == CH_QUOTE) begin
          mode = PM_QUOTED;
        end else begin
          mode   = PM_UNQ;
          ws_cnt = 0;
          emit(K_BYTE, c, 3'd0);
        end
      end
      PM_UNQ: begin
        if (ws) begin
          if (ws_cnt >= PENDING_MAX) begin
            flag_error(E_WS_OVF);
          end else begin
            ws_hold[ws_cnt] = c;
            ws_cnt++;
          end
        end else if (c == CH_COMMA) begin
          close_field(1'b0);
        end else if (c == CH_NL) begin
          close_field(1'b1);
        end else begin
          for (int i = 0; i < ws_cnt; i++) emit(K_BYTE, ws_hold[i], 3'd0);
          ws_cnt = 0;
          emit(K_BYTE, c, 3'd0);
        end
      end
      PM_QUOTED: begin
        if (c == CH_QUOTE) mode = PM_QSEEN;
        else emit(K_BYTE, c, 3'd0);
      end
      PM_QSEEN: begin
        if (c == CH_QUOTE) begin
          mode = PM_QUOTED;
          emit(K_BYTE, c, 3'd0);
        end else if (ws) begin
          mode = PM_AFTER;
        end else if (c == CH_COMMA) begin
          close_field(1'b0);
        end else if (c == CH_NL) begin
          close_field(1'b1);
        end else begin
          flag_error(E_AFTER_Q);
        end
      end
      PM_AFTER: begin
        if (ws) begin
        end else if (c == CH_COMMA) begin
          close_field(1'b0);
        end else if (c == CH_NL) begin
          close_field(1'b1);
        end else begin
          flag_error(E_AFTER_Q);
        end
      end
      default: ;
    endcase
  endfunction

  function void tokenize_item(logic k, logic [7:0] b);
    int unsigned base;
    cft_res_t    r;
    if (err_hold || mode > PM_AFTER) return;
    base = expected_tokens_q.size();
    if (k) take_eof();
    else take_byte(b);
    if (expected_tokens_q.size() > base) begin
      r = expected_tokens_q.pop_back();
      r.last = 1'b1;
      expected_tokens_q.push_back(r);
    end
  endfunction

  function void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_total++;
    end
  endfunction

  function void compare_token();
    cft_res_t want;
    if (expected_tokens_q.size() == 0) begin
      $error("unexpected token: out_kind %0d data_byte 0x%02h column %0d error_code %0d",
             out_kind, out_data_byte, out_column, out_error_code);
      err_total++;
      return;
    end
    want = expected_tokens_q.pop_front();
    check_field("out_kind", 8'(want.out_kind), 8'(out_kind));
    check_field("data_byte", want.data_byte, out_data_byte);
    check_field("column", 8'(want.column), 8'(out_column));
    check_field("in_header", 8'(want.in_header), 8'(out_in_header));
    check_field("error_code", 8'(want.error_code), 8'(out_error_code));
    check_field("last", 8'(want.last), 8'(out_last));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_tokenizer();
      expected_tokens_q.delete();
      err_total   = 0;
      outstanding <= 0;
    end else begin
      if (in_valid && in_ready) tokenize_item(in_kind, in_byte);
      if (out_valid && out_ready) compare_token();
      outstanding <= expected_tokens_q.size();
    end
  end

endmodule

>>> tb/tb_csv_field_tokenizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_csv_field_tokenizer_top
// Feeds one CSV stream per run into the tokenizer: a scenario picked at
// random (short directed file, random table, very wide header, empty file or
// header cut by end of file), then trailing noise, most of them after a random ending.
// The sender works in bursts, the receiver stalls on its own pattern, and
// the checker beside the block judges every token.
// ----------------------------------------------------------------------------
module tb_csv_field_tokenizer_top import cft_pkg::*; ();

  localparam int BODY_ITEMS = 200;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } feed_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned fail_count;
  int unsigned outstanding;
  feed_t       feed_q[$];

  cft_in_if  din ();
  cft_out_if dout ();

  csv_field_tokenizer_top u_top (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  cft_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (din.valid),
    .in_ready       (din.ready),
    .in_kind        (din.kind),
    .in_byte        (din.byte_in),
    .out_valid      (dout.valid),
    .out_ready      (dout.ready),
    .out_kind       (dout.out_kind),
    .out_data_byte  (dout.data_byte),
    .out_column     (dout.column),
    .out_in_header  (dout.in_header),
    .out_error_code (dout.error_code),
    .out_last       (dout.last),
    .fail_count     (fail_count),
    .outstanding    (outstanding)
  );

  always #10 clk = ~clk;

  function automatic void put_byte(logic [7:0] b);
    feed_t f;
    f.kind = 1'b0;
    f.data = b;
    feed_q.push_back(f);
  endfunction

  function automatic void put_eof();
    feed_t f;
    f.kind = 1'b1;
    f.data = 8'($urandom_range(0, 255));
    feed_q.push_back(f);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic logic [7:0] pick_ws();
    return ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB;
  endfunction

  function automatic void put_ws_run(int n);
    repeat (n) put_byte(pick_ws());
  endfunction

  function automatic logic [7:0] pick_text(bit allow_quote);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_SPACE || b == CH_TAB || b == CH_COMMA || b == CH_NL ||
           (!allow_quote && b == CH_QUOTE));
    return b;
  endfunction

  function automatic void add_unquoted(bit brief);
    int segs;
    put_ws_run($urandom_range(0, 2));
    put_byte(pick_text(1'b0));
    segs = brief ? 0 : $urandom_range(0, 3);
    repeat (segs) begin
      if ($urandom_range(0, 2) == 0)
        put_ws_run(($urandom_range(0, 7) == 0) ? PENDING_MAX : $urandom_range(1, 4));
      put_byte(pick_text(1'b1));
    end
    put_ws_run(($urandom_range(0, 9) == 0) ? PENDING_MAX : $urandom_range(0, 2));
  endfunction

  function automatic void add_quoted(bit brief, bit closed);
    int         len;
    logic [7:0] b;
    put_ws_run($urandom_range(0, 1));
    put_byte(CH_QUOTE);
    len = brief ? $urandom_range(0, 1) : $urandom_range(0, 5);
    repeat (len) begin
      b = ($urandom_range(0, 7) == 0) ? CH_QUOTE : 8'($urandom_range(0, 255));
      put_byte(b);
      if (b == CH_QUOTE) put_byte(CH_QUOTE);
    end
    if (closed) begin
      put_byte(CH_QUOTE);
      put_ws_run($urandom_range(0, 2));
    end
  endfunction

  function automatic void add_field(bit brief);
    case ($urandom_range(0, 9))
      0, 1:          put_ws_run($urandom_range(0, 1));
      2, 3, 4, 5, 6: add_unquoted(brief);
      default:       add_quoted(brief, 1'b1);
    endcase
  endfunction

  function automatic void add_row(int ncol, bit brief);
    for (int c = 0; c < ncol; c++) begin
      add_field(brief);
      put_byte((c == ncol - 1) ? CH_NL : CH_COMMA);
    end
  endfunction

  function automatic void add_noise();
    put_eof();
    repeat ($urandom_range(8, 16)) begin
      if ($urandom_range(0, 3) == 0) put_eof();
      else put_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void add_ending(int ncol);
    case ($urandom_range(0, 6))
      0: ;
      1: repeat ($urandom_range(1, ncol)) begin
        add_field(1'b1);
        put_byte(CH_COMMA);
      end
      2: begin
        repeat (ncol - 1) begin
          add_field(1'b1);
          put_byte(CH_COMMA);
        end
        case ($urandom_range(0, 2))
          0:       add_unquoted(1'b0);
          1:       add_quoted(1'b0, 1'b1);
          default: add_quoted(1'b0, 1'b0);
        endcase
      end
      3: begin
        put_byte(CH_QUOTE);
        put_byte(pick_text(1'b0));
        put_byte(CH_QUOTE);
        put_ws_run($urandom_range(0, 2));
        put_byte(pick_text(1'b0));
      end
      4: repeat (ncol) begin
        add_field(1'b1);
        put_byte(CH_COMMA);
      end
      5: begin
        add_field(1'b1);
        put_byte((ncol >= 2) ? CH_NL : CH_COMMA);
      end
      default: begin
        put_byte(pick_text(1'b0));
        put_ws_run(PENDING_MAX + 1);
      end
    endcase
    add_noise();
  endfunction

  function automatic void build_stream();
    int pick;
    int ncol;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      put_ws_run($urandom_range(0, 3));
      add_noise();
    end else if (pick == 1) begin
      repeat ($urandom_range(1, 3)) begin
        add_field(1'b0);
        put_byte(CH_COMMA);
      end
      add_noise();
    end else if (pick < 4) begin
      for (int c = 0; c < MAX_COLUMNS; c++) begin
        add_field(1'b1);
        if (c < MAX_COLUMNS - 1) put_byte(CH_COMMA);
      end
      if ($urandom_range(0, 1) != 0) begin
        put_byte(CH_COMMA);
        add_noise();
      end else begin
        put_byte(CH_NL);
        add_row(MAX_COLUMNS, 1'b1);
        add_ending(MAX_COLUMNS);
      end
    end else begin
      if (pick < 12) begin
        ncol = 3;
        put_text("\t\"h\"\"1\" ,x y\t,\"\"\n");
        put_byte("a");
        for (int i = 0; i < PENDING_MAX; i++) put_byte(i[0] ? CH_TAB : CH_SPACE);
        put_text("b,\"");
        put_byte(8'h00);
        put_byte(8'hFF);
        put_text(",\n\",");
        put_byte(8'h80);
        put_byte(CH_NL);
      end else begin
        ncol = $urandom_range(1, 6);
        add_row(ncol, 1'b0);
      end
      while (feed_q.size() < BODY_ITEMS) add_row(ncol, 1'b0);
      add_ending(ncol);
    end
  endfunction

  task automatic drive_stream();
    int burst;
    int gap;
    burst = $urandom_range(1, 24);
    foreach (feed_q[i]) begin
      if (burst == 0) begin
        din.valid <= 1'b0;
        gap = $urandom_range(1, 6);
        repeat (gap) @(posedge clk);
        burst = ($urandom_range(0, 4) == 0) ? 300 : $urandom_range(1, 24);
      end
      din.valid   <= 1'b1;
      din.kind    <= feed_q[i].kind;
      din.byte_in <= feed_q[i].data;
      @(posedge clk);
      while (!din.ready) @(posedge clk);
      burst--;
    end
    din.valid <= 1'b0;
  endtask

  initial begin : sink_pacing
    int mode;
    int span;
    int hold;
    mode = 0;
    span = 0;
    hold = 0;
    dout.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 200);
      end
      span--;
      case (mode)
        0: dout.ready <= 1'b1;
        1: dout.ready <= ($urandom_range(0, 1) != 0);
        2: dout.ready <= ($urandom_range(0, 3) == 0);
        default: begin
          if (hold == 0) hold = $urandom_range(2, 10);
          hold--;
          dout.ready <= (hold < 2);
        end
      endcase
    end
  end

  initial begin : stimulus
    din.valid   <= 1'b0;
    din.kind    <= 1'b0;
    din.byte_in <= 8'h00;
    build_stream();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    drive_stream();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/cft_pkg.sv
rtl/core/cft_ifs.sv
rtl/core/cft_parse.sv
rtl/core/cft_emit.sv
rtl/core/csv_field_tokenizer_top.sv
tb/cft_checker.sv
tb/tb_csv_field_tokenizer_top.sv
